FILE: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and codes for the ordered list table: request and response
// beats, operation codes, status codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package olt_pkg;

    // Request selector codes
    localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
    localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [2:0] FN_INSERT_AT  = 3'd2;
    localparam logic [2:0] FN_FIND       = 3'd3;
    localparam logic [2:0] FN_POP_BACK   = 3'd4;
    localparam logic [2:0] FN_POP_FRONT  = 3'd5;
    localparam logic [2:0] FN_DELETE_AT  = 3'd6;

    // Response status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [8:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [7:0]         found_index;
        logic [1:0]         status;
        logic [8:0]         count;
    } t_rsp;

    // Kind of memory walk a request needs
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_FIND
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RUN,
        S_COMMIT,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic setup;
        logic step;
        logic commit;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  dec_op;
        logic run_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/olt_ctrl.sv
// ----------------------------------------------------------------------------
// olt_ctrl
// Request sequencer: accept a beat, decode it, walk the memory, commit the
// count and hand the response to the output register.
// ----------------------------------------------------------------------------
module olt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output olt_pkg::t_cmd o_cmd,
    input  olt_pkg::t_sts i_sts
);
    import olt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.setup = 1'b1;
                // rejected and unused requests go straight to the response
                n_state = (i_sts.dec_op == OP_NONE) ? S_DONE : S_RUN;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.run_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/olt_dp.sv
// ----------------------------------------------------------------------------
// olt_dp
// List datapath: entry memory, element count, request decode, walk
// counters for shift and search, and the response register.
// ----------------------------------------------------------------------------
module olt_dp #(
    parameter int DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  olt_pkg::t_req i_in_data,
    input  olt_pkg::t_cmd i_cmd,
    output olt_pkg::t_sts o_sts,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output olt_pkg::t_rsp o_out_data
);
    import olt_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int POSW = $bits(i_in_data.position);
    localparam int PW   = (CW > POSW) ? CW : POSW;

    logic [31:0] mem [DEPTH];

    t_req               r_req;
    logic [CW-1:0]      r_count;
    t_op                r_op;
    logic [1:0]         r_status;
    logic [AW-1:0]      r_at;
    logic [AW-1:0]      r_ra;
    logic [CW-1:0]      r_left;
    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;
    logic [31:0]        r_rd_data;
    logic signed [31:0] r_res_value;
    logic [AW-1:0]      r_fidx;
    logic               r_found;
    logic               r_out_valid;
    t_rsp               r_out;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          full;
    logic          empty;
    t_op           dec_op;
    logic [1:0]    dec_status;
    logic [AW-1:0] dec_at;
    logic [CW-1:0] dec_left;
    logic [AW-1:0] dec_ra;

    logic          rd_en;
    logic          pend_act;
    logic          match;
    logic          grab;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // ---------------- request decode ----------------
    assign pos_ext = PW'(r_req.position);
    assign cnt_ext = PW'(r_count);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);

    always_comb begin
        dec_op     = OP_NONE;
        dec_status = ST_OK;
        dec_at     = '0;
        unique case (r_req.func)
            FN_PUSH_BACK: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op = OP_INSERT;
                    dec_at = AW'(r_count);
                end
            end
            FN_PUSH_FRONT: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op = OP_INSERT;
                end
            end
            FN_INSERT_AT: begin
                if (pos_ext > cnt_ext) begin
                    dec_status = ST_BADPOS;
                end else if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op = OP_INSERT;
                    dec_at = AW'(r_req.position);
                end
            end
            FN_FIND: begin
                // stays empty/not found unless the walk hits the value
                dec_op     = OP_FIND;
                dec_status = ST_EMPTY;
            end
            FN_POP_BACK: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op = OP_REMOVE;
                    dec_at = AW'(r_count - CW'(1));
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op = OP_REMOVE;
                end
            end
            FN_DELETE_AT: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    dec_status = ST_BADPOS;
                end else begin
                    dec_op = OP_REMOVE;
                    dec_at = AW'(r_req.position);
                end
            end
            default: begin
            end
        endcase
    end

    // Insert reads count-1 down to at; remove reads at up to count-1;
    // find reads 0 up to count-1.
    always_comb begin
        unique case (dec_op)
            OP_INSERT: begin
                dec_left = r_count - CW'(dec_at);
                dec_ra   = AW'(r_count - CW'(1));
            end
            OP_REMOVE: begin
                dec_left = r_count - CW'(dec_at);
                dec_ra   = dec_at;
            end
            OP_FIND: begin
                dec_left = r_count;
                dec_ra   = '0;
            end
            default: begin
                dec_left = '0;
                dec_ra   = '0;
            end
        endcase
    end

    // ---------------- walk ----------------
    assign rd_en    = i_cmd.step && (r_left != '0);
    assign pend_act = i_cmd.step && r_pend;
    assign match    = pend_act && (r_op == OP_FIND) && !r_found &&
                      (r_rd_data == r_req.value);
    assign grab     = pend_act && (r_op == OP_REMOVE) && (r_pend_addr == r_at);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        priority if (pend_act && (r_op == OP_INSERT)) begin
            // open the gap: move one place up
            wr_en   = 1'b1;
            wr_addr = r_pend_addr + AW'(1);
            wr_data = r_rd_data;
        end else if (pend_act && (r_op == OP_REMOVE) && (r_pend_addr != r_at)) begin
            // close the gap: move one place down
            wr_en   = 1'b1;
            wr_addr = r_pend_addr - AW'(1);
            wr_data = r_rd_data;
        end else if (i_cmd.commit && (r_op == OP_INSERT)) begin
            wr_en   = 1'b1;
            wr_addr = r_at;
            wr_data = r_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_ra];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_op        <= OP_NONE;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_op    <= dec_op;
                r_left  <= dec_left;
                r_found <= 1'b0;
            end else if (rd_en) begin
                r_left <= r_left - CW'(1);
            end
            r_pend <= rd_en;
            if (match) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_op == OP_INSERT) begin
                    r_count <= r_count + CW'(1);
                end else if (r_op == OP_REMOVE) begin
                    r_count <= r_count - CW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_data;
        end
        if (i_cmd.setup) begin
            r_status    <= dec_status;
            r_at        <= dec_at;
            r_ra        <= dec_ra;
            r_res_value <= '0;
            r_fidx      <= '0;
        end else if (rd_en) begin
            r_ra <= (r_op == OP_INSERT) ? (r_ra - AW'(1)) : (r_ra + AW'(1));
        end
        if (rd_en) begin
            r_pend_addr <= r_ra;
        end
        if (match) begin
            r_status <= ST_OK;
            r_fidx   <= r_pend_addr;
        end
        if (grab) begin
            r_res_value <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_out.result_value <= r_res_value;
            r_out.found_index  <= 8'(r_fidx);
            r_out.status       <= r_status;
            r_out.count        <= 9'(r_count);
        end
    end

    assign o_sts.dec_op   = dec_op;
    assign o_sts.run_done = (r_left == '0) && !r_pend;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/ordered_list_table.sv
// ----------------------------------------------------------------------------
// ordered_list_table
// Ordered list of up to DEPTH signed 32-bit values with push, pop, insert,
// delete and find requests, one response beat per request.
// ----------------------------------------------------------------------------
// One request is worked at a time. An accepted request is decoded, then
// walks the entry memory (one read port and one write port), reading
// count - position entries for insert and delete, count for find, push
// front and pop front, one for pop back, and none for push back, insert
// at the end or find on an empty list; then the commit state updates the
// count and the response register is loaded. A rejected request or an
// unused selector skips the walk and the commit. The input opens again
// the cycle after the load, so the longest gap between accepted requests
// is set by a find over a full list. The memory moves one entry per cycle
// (read one slot, write its neighbor the next cycle). The response sits in
// an output register, so the next request is taken while it waits; a
// response still stalled there holds the following one until it drains.
// Entries hold no reset value; the count and control state clear at reset.
module ordered_list_table #(
    parameter int DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  olt_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output olt_pkg::t_rsp o_out_data
);
    import olt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    olt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    olt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/olt_checker.sv
// ----------------------------------------------------------------------------
// olt_checker
// Port-level checks for the ordered list table, bound to the top level.
// ----------------------------------------------------------------------------
module olt_checker #(
    parameter int DEPTH = 256
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input olt_pkg::t_req i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input olt_pkg::t_rsp o_out_data
);
    import olt_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic       r_have;
    logic [8:0] r_last;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // track the count of the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_last <= '0;
        end else if (out_acc) begin
            r_have <= 1'b1;
            r_last <= o_out_data.count;
        end
    end

    // one request in flight: accepting a beat closes the input
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while a request is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled response beat changed");

    // each request moves the count by at most one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_have) |-> (o_out_data.count == r_last ||
                                 o_out_data.count == r_last + 9'd1 ||
                                 o_out_data.count == r_last - 9'd1))
        else $error("count jumped by more than one");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FULL) |->
            (o_out_data.count == 9'(DEPTH)))
        else $error("full status with a list that is not full");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
            (o_out_data.result_value == '0 && o_out_data.found_index == '0))
        else $error("failed request carries a value or index");

endmodule

bind ordered_list_table olt_checker #(
    .DEPTH (DEPTH)
) u_olt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
